// ----- src/dbm_seq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disk buffer manager sequencer package
// Shared payload and state types, event codes, flag positions and the
// timing constants of the buffer manager and mechanism sequencer.
// ----------------------------------------------------------------------------
package dbm_seq_pkg;

  localparam int DATA_SECTORS_DEF = 85;
  localparam int SEC_PER_BLK      = 90;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_CTL    = 3'd1;
  localparam logic [2:0] MODE_SEEK   = 3'd2;
  localparam logic [2:0] MODE_STATUS = 3'd3;
  localparam logic [2:0] MODE_MECHA  = 3'd4;
  localparam logic [2:0] MODE_REZERO = 3'd5;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_ZERO  = 2'd3;

  localparam logic [1:0] EVT_NONE  = 2'd0;
  localparam logic [1:0] EVT_TICK  = 2'd1;
  localparam logic [1:0] EVT_MECHA = 2'd2;

  localparam int CANCEL_TICK  = 0;
  localparam int CANCEL_MECHA = 1;

  localparam int FLG_DRQ = 0;
  localparam int FLG_C2  = 1;
  localparam int FLG_BMI = 2;
  localparam int FLG_MCI = 3;
  localparam int FLG_RUN = 4;
  localparam int FLG_BLK = 5;
  localparam int FLG_MIC = 6;

  localparam logic [11:0] FAIL_TRACK = 12'd6;

  localparam logic [24:0] START_DELAY  = 25'd12500;
  localparam logic [24:0] ACK_BASE     = 25'd8020;
  localparam logic [24:0] SEEK_BASE    = 25'd248250;
  localparam logic [24:0] SEEK_STEP    = 25'd4825;
  // Track divided by 56 is (track / 8) * 293 / 2048, exact for 12-bit tracks.
  localparam logic [17:0] DIV7_RECIP   = 18'd293;
  localparam int          DIV7_SHIFT   = 11;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  start_sector;
    logic        ctl_start;
    logic        ctl_blk_trans;
    logic        ctl_reset;
    logic        ctl_mecha_rst;
    logic [11:0] seek_track;
    logic        seek_head;
    logic        seek_write;
  } dbm_in_t;

  typedef struct packed {
    logic [6:0]  status_flags;
    logic        irq_line;
    logic [7:0]  cur_sector;
    logic [1:0]  disk_op;
    logic        op_head;
    logic [11:0] op_track;
    logic        op_block;
    logic [6:0]  op_sector;
    logic [1:0]  event_kind;
    logic [24:0] event_delay;
    logic [1:0]  cancel_events;
  } dbm_out_t;

  typedef struct packed {
    logic [7:0]  sector_count;
    logic [11:0] track_reg;
    logic        head_reg;
    logic        write_dir;
    logic [6:0]  flag_bits;
    logic        reset_held;
    logic        irq_reg;
  } dbm_state_t;

endpackage

// ----- src/dbm_seq_calc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disk buffer manager event logic
// Works out the next controller state and the result of one event from the
// registered event and the current state.
// ----------------------------------------------------------------------------
module dbm_seq_calc #(
  parameter int DATA_SECTORS = dbm_seq_pkg::DATA_SECTORS_DEF
) (
  input  dbm_seq_pkg::dbm_in_t    item,
  input  dbm_seq_pkg::dbm_state_t st,
  input  logic                    dev_unit,
  output dbm_seq_pkg::dbm_state_t st_nxt,
  output dbm_seq_pkg::dbm_out_t   res
);

  localparam logic [6:0] DATA_END  = 7'(DATA_SECTORS);
  localparam logic [6:0] C2_END    = 7'(DATA_SECTORS + 3);
  localparam logic [7:0] SPB8      = 8'(dbm_seq_pkg::SEC_PER_BLK);
  localparam logic [7:0] SPB8_X2   = 8'(2 * dbm_seq_pkg::SEC_PER_BLK);

  logic [1:0]  blk;
  logic [7:0]  blk_off;
  logic [7:0]  sec8;
  logic [6:0]  sec;
  logic [7:0]  cnt_inc;
  logic [7:0]  jump_base;
  logic [6:0]  f;
  logic [11:0] seek_tgt;
  logic [11:0] seek_diff;
  logic [24:0] seek_delay;
  logic [17:0] div_prod;
  logic [24:0] ack_delay;
  logic        read_fail;

  always_comb begin
    if (st.sector_count >= SPB8_X2) begin
      blk     = 2'd2;
      blk_off = SPB8_X2;
    end else if (st.sector_count >= SPB8) begin
      blk     = 2'd1;
      blk_off = SPB8;
    end else begin
      blk     = 2'd0;
      blk_off = 8'd0;
    end
    sec8      = st.sector_count - blk_off;
    sec       = sec8[6:0];
    cnt_inc   = st.sector_count + 8'd1;
    jump_base = SPB8 - blk_off;
    read_fail = !st.head_reg && (st.track_reg == dbm_seq_pkg::FAIL_TRACK) &&
                (blk == 2'd0) && !dev_unit;

    seek_tgt   = (item.mode == dbm_seq_pkg::MODE_SEEK) ? item.seek_track : 12'd0;
    seek_diff  = (seek_tgt > st.track_reg) ? seek_tgt - st.track_reg
                                           : st.track_reg - seek_tgt;
    seek_delay = dbm_seq_pkg::SEEK_BASE + 25'(seek_diff) * dbm_seq_pkg::SEEK_STEP;

    div_prod  = 18'(st.track_reg[11:3]) * dbm_seq_pkg::DIV7_RECIP;
    ack_delay = dbm_seq_pkg::ACK_BASE + 25'(div_prod[17:dbm_seq_pkg::DIV7_SHIFT]);
  end

  always_comb begin
    st_nxt = st;
    f      = st.flag_bits;
    res    = '0;

    unique case (item.mode)
      dbm_seq_pkg::MODE_TICK: begin
        if (f[dbm_seq_pkg::FLG_RUN]) begin
          f[dbm_seq_pkg::FLG_DRQ] = 1'b0;
          f[dbm_seq_pkg::FLG_C2]  = 1'b0;
          if (st.write_dir) begin
            if (sec == 7'd0) begin
              st_nxt.sector_count     = cnt_inc;
              f[dbm_seq_pkg::FLG_DRQ] = 1'b1;
            end else if (sec <= DATA_END) begin
              res.disk_op   = dbm_seq_pkg::OP_WRITE;
              res.op_head   = st.head_reg;
              res.op_track  = st.track_reg;
              res.op_block  = blk[0];
              res.op_sector = sec - 7'd1;
              if (sec < DATA_END) begin
                st_nxt.sector_count     = cnt_inc;
                f[dbm_seq_pkg::FLG_DRQ] = 1'b1;
              end else if (f[dbm_seq_pkg::FLG_BLK]) begin
                st_nxt.sector_count     = jump_base + 8'd1;
                f[dbm_seq_pkg::FLG_BLK] = 1'b0;
                f[dbm_seq_pkg::FLG_DRQ] = 1'b1;
              end else begin
                st_nxt.sector_count     = cnt_inc;
                f[dbm_seq_pkg::FLG_RUN] = 1'b0;
              end
            end
          end else begin
            if (read_fail) begin
              f[dbm_seq_pkg::FLG_MIC] = 1'b1;
            end else if (sec <= C2_END) begin
              res.op_head   = st.head_reg;
              res.op_track  = st.track_reg;
              res.op_block  = blk[0];
              res.op_sector = sec;
              if (sec < DATA_END) begin
                res.disk_op             = dbm_seq_pkg::OP_READ;
                st_nxt.sector_count     = cnt_inc;
                f[dbm_seq_pkg::FLG_DRQ] = 1'b1;
              end else if (sec < C2_END) begin
                res.disk_op         = dbm_seq_pkg::OP_ZERO;
                st_nxt.sector_count = cnt_inc;
              end else begin
                res.disk_op            = dbm_seq_pkg::OP_ZERO;
                f[dbm_seq_pkg::FLG_C2] = 1'b1;
                if (f[dbm_seq_pkg::FLG_BLK]) begin
                  st_nxt.sector_count     = jump_base;
                  f[dbm_seq_pkg::FLG_BLK] = 1'b0;
                end else begin
                  f[dbm_seq_pkg::FLG_RUN] = 1'b0;
                end
              end
            end
          end
          f[dbm_seq_pkg::FLG_BMI] = 1'b1;
          st_nxt.irq_reg          = 1'b1;
        end
      end
      dbm_seq_pkg::MODE_CTL: begin
        st_nxt.sector_count = item.start_sector;
        if (item.ctl_mecha_rst) begin
          f[dbm_seq_pkg::FLG_MCI]                  = 1'b0;
          res.cancel_events[dbm_seq_pkg::CANCEL_MECHA] = 1'b1;
        end
        if (item.ctl_blk_trans) begin
          f[dbm_seq_pkg::FLG_BLK] = 1'b1;
        end
        if (item.ctl_reset) begin
          st_nxt.reset_held = 1'b1;
        end else if (st.reset_held) begin
          st_nxt.reset_held   = 1'b0;
          f                   = f & (7'd1 << dbm_seq_pkg::FLG_MCI);
          st_nxt.sector_count = 8'd0;
          res.cancel_events[dbm_seq_pkg::CANCEL_TICK] = 1'b1;
        end
        if (!f[dbm_seq_pkg::FLG_BMI] && !f[dbm_seq_pkg::FLG_MCI]) begin
          st_nxt.irq_reg = 1'b0;
        end
        if (item.ctl_start) begin
          f[dbm_seq_pkg::FLG_RUN] = 1'b1;
          res.event_kind          = dbm_seq_pkg::EVT_TICK;
          res.event_delay         = dbm_seq_pkg::START_DELAY;
        end
      end
      dbm_seq_pkg::MODE_SEEK, dbm_seq_pkg::MODE_REZERO: begin
        st_nxt.track_reg = seek_tgt;
        if (item.mode == dbm_seq_pkg::MODE_SEEK) begin
          st_nxt.head_reg  = item.seek_head;
          st_nxt.write_dir = item.seek_write;
        end else begin
          st_nxt.head_reg  = 1'b0;
          st_nxt.write_dir = 1'b1;
        end
        res.event_kind  = dbm_seq_pkg::EVT_MECHA;
        res.event_delay = seek_delay;
      end
      dbm_seq_pkg::MODE_STATUS: begin
        if (f[dbm_seq_pkg::FLG_BMI]) begin
          f[dbm_seq_pkg::FLG_BMI] = 1'b0;
          st_nxt.irq_reg          = 1'b0;
          res.event_kind          = dbm_seq_pkg::EVT_TICK;
          res.event_delay         = ack_delay;
        end
      end
      dbm_seq_pkg::MODE_MECHA: begin
        f[dbm_seq_pkg::FLG_MCI] = 1'b1;
        st_nxt.irq_reg          = 1'b1;
      end
      default: begin
      end
    endcase

    st_nxt.flag_bits = f;
    res.status_flags = (item.mode == dbm_seq_pkg::MODE_STATUS) ? st.flag_bits : f;
    res.irq_line     = st_nxt.irq_reg;
    res.cur_sector   = st_nxt.sector_count;
  end

endmodule

// ----- src/disk_buffer_manager_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disk buffer manager sequencer core
// Sector counter, head, track, direction and status flags of the disk
// buffer manager, updated by one event per transfer.
//
//   Channel  Ports                        Contents
//   input    in_valid / in_stall / in_data     one event
//   result   out_valid / out_stall / out_data  status, storage op, next event
//   config   cfg_wr_en / cfg_wr_data           development drive bit
//
// An event is registered on acceptance and its result is registered in the
// result register once that register can advance, which a stall can delay.
// One event is taken every cycle while the result is not stalled; the state
// update sits between the input register and the result register.
// A stalled result holds the pipe; the input register then fills and
// in_stall rises.
// Reset (rst_n low, synchronous) clears the state, the config bit and both
// valid flags.
// ----------------------------------------------------------------------------
module disk_buffer_manager_sequencer_core #(
  parameter int DATA_SECTORS = dbm_seq_pkg::DATA_SECTORS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dbm_seq_pkg::dbm_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dbm_seq_pkg::dbm_out_t out_data,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data
);

  logic                    in_vld_r;
  dbm_seq_pkg::dbm_in_t    in_data_r;
  logic                    out_vld_r;
  dbm_seq_pkg::dbm_out_t   out_data_r;
  dbm_seq_pkg::dbm_state_t st_r;
  dbm_seq_pkg::dbm_state_t st_nxt;
  dbm_seq_pkg::dbm_out_t   res_nxt;
  logic                    dev_unit_r;
  logic                    adv;

  assign adv       = !out_vld_r || !out_stall;
  assign in_stall  = in_vld_r && !adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  dbm_seq_calc #(
    .DATA_SECTORS(DATA_SECTORS)
  ) u_calc (
    .item    (in_data_r),
    .st      (st_r),
    .dev_unit(dev_unit_r),
    .st_nxt  (st_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      st_r       <= '0;
      dev_unit_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dev_unit_r <= cfg_wr_data;
      end
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
        if (in_vld_r) begin
          st_r <= st_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
    if (adv && in_vld_r) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

// ----- src/dbm_seq_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disk buffer manager sequencer checker
// Port-level checks on the result channel of the sequencer core.
// ----------------------------------------------------------------------------
module dbm_seq_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input dbm_seq_pkg::dbm_out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or dropped.");

  a_no_op_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.disk_op == dbm_seq_pkg::OP_NONE) |->
      !out_data.op_head && (out_data.op_track == 12'd0) &&
      !out_data.op_block && (out_data.op_sector == 7'd0))
    else $error("Address given without a storage operation.");

  a_no_evt_delay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind == dbm_seq_pkg::EVT_NONE) |->
      (out_data.event_delay == 25'd0))
    else $error("Delay given without an event.");

  a_irq_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.irq_line |->
      out_data.status_flags[dbm_seq_pkg::FLG_BMI] ||
      out_data.status_flags[dbm_seq_pkg::FLG_MCI])
    else $error("Interrupt line high with no interrupt pending.");

endmodule

bind disk_buffer_manager_sequencer_core dbm_seq_chk u_dbm_seq_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disk buffer manager sequencer testbench
// Drives events into the sequencer core and checks every result against a
// cycle-free prediction of the flags, sector counter, storage operation and
// scheduled event. A short directed run covers the corner cases. Random
// transfers follow, each a seek or rezero, a control write and a train of
// ticks with status reads, mixed with random noise events. Both sides idle
// at random, the receiver holds off once for a long stretch, and the
// development drive bit is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [2:0] MODE_UNUSED = 3'd6;
  localparam int         ACK_TRACK_DIV = 56;
  localparam int         RANDOM_EVENTS = 1250;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         HOLD_CYCLES = 300;

  class dbm_scoreboard;
    dbm_seq_pkg::dbm_state_t st;
    bit                      dev_unit;
    dbm_seq_pkg::dbm_out_t   expected_q[$];
    int                      errors;

    function new();
      st = '0;
      dev_unit = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit running();
      return st.flag_bits[dbm_seq_pkg::FLG_RUN];
    endfunction

    function void mark_op(inout dbm_seq_pkg::dbm_out_t r, input logic [1:0] op,
                          input int count);
      int c;
      c = count & 255;
      r.disk_op = op;
      r.op_head = st.head_reg;
      r.op_track = st.track_reg;
      r.op_block = 1'((c / dbm_seq_pkg::SEC_PER_BLK) % 2);
      r.op_sector = 7'(c % dbm_seq_pkg::SEC_PER_BLK);
    endfunction

    function void advance_sector(inout dbm_seq_pkg::dbm_out_t r);
      int s;
      int blk;
      int sec;
      if (!st.flag_bits[dbm_seq_pkg::FLG_RUN]) return;
      st.flag_bits[dbm_seq_pkg::FLG_DRQ] = 1'b0;
      st.flag_bits[dbm_seq_pkg::FLG_C2] = 1'b0;
      s = st.sector_count;
      blk = s / dbm_seq_pkg::SEC_PER_BLK;
      sec = s % dbm_seq_pkg::SEC_PER_BLK;
      if (st.write_dir) begin
        if (sec == 0) begin
          st.sector_count = 8'(s + 1);
          st.flag_bits[dbm_seq_pkg::FLG_DRQ] = 1'b1;
        end else if (sec < dbm_seq_pkg::DATA_SECTORS_DEF) begin
          mark_op(r, dbm_seq_pkg::OP_WRITE, s - 1);
          st.sector_count = 8'(s + 1);
          st.flag_bits[dbm_seq_pkg::FLG_DRQ] = 1'b1;
        end else if (sec == dbm_seq_pkg::DATA_SECTORS_DEF) begin
          mark_op(r, dbm_seq_pkg::OP_WRITE, s - 1);
          if (st.flag_bits[dbm_seq_pkg::FLG_BLK]) begin
            st.sector_count = 8'((1 - blk) * dbm_seq_pkg::SEC_PER_BLK + 1);
            st.flag_bits[dbm_seq_pkg::FLG_BLK] = 1'b0;
            st.flag_bits[dbm_seq_pkg::FLG_DRQ] = 1'b1;
          end else begin
            st.sector_count = 8'(s + 1);
            st.flag_bits[dbm_seq_pkg::FLG_RUN] = 1'b0;
          end
        end
      end else begin
        if (!st.head_reg && st.track_reg == dbm_seq_pkg::FAIL_TRACK && blk == 0 &&
            !dev_unit) begin
          st.flag_bits[dbm_seq_pkg::FLG_DRQ] = 1'b0;
          st.flag_bits[dbm_seq_pkg::FLG_MIC] = 1'b1;
        end else if (sec < dbm_seq_pkg::DATA_SECTORS_DEF) begin
          mark_op(r, dbm_seq_pkg::OP_READ, s);
          st.sector_count = 8'(s + 1);
          st.flag_bits[dbm_seq_pkg::FLG_DRQ] = 1'b1;
        end else if (sec < dbm_seq_pkg::DATA_SECTORS_DEF + 3) begin
          mark_op(r, dbm_seq_pkg::OP_ZERO, s);
          st.sector_count = 8'(s + 1);
        end else if (sec == dbm_seq_pkg::DATA_SECTORS_DEF + 3) begin
          mark_op(r, dbm_seq_pkg::OP_ZERO, s);
          st.flag_bits[dbm_seq_pkg::FLG_C2] = 1'b1;
          if (st.flag_bits[dbm_seq_pkg::FLG_BLK]) begin
            st.sector_count = 8'((1 - blk) * dbm_seq_pkg::SEC_PER_BLK);
            st.flag_bits[dbm_seq_pkg::FLG_BLK] = 1'b0;
          end else begin
            st.flag_bits[dbm_seq_pkg::FLG_RUN] = 1'b0;
          end
        end
      end
      st.flag_bits[dbm_seq_pkg::FLG_BMI] = 1'b1;
      st.irq_reg = 1'b1;
    endfunction

    function void move_head(inout dbm_seq_pkg::dbm_out_t r, input logic [11:0] trk,
                            input logic hd, input logic wr);
      int diff;
      diff = (int'(trk) > int'(st.track_reg)) ? int'(trk) - int'(st.track_reg)
                                              : int'(st.track_reg) - int'(trk);
      st.track_reg = trk;
      st.head_reg = hd;
      st.write_dir = wr;
      r.event_kind = dbm_seq_pkg::EVT_MECHA;
      r.event_delay = 25'(dbm_seq_pkg::SEEK_BASE + dbm_seq_pkg::SEEK_STEP * diff);
    endfunction

    function dbm_seq_pkg::dbm_out_t predict(dbm_seq_pkg::dbm_in_t ev);
      dbm_seq_pkg::dbm_out_t r;
      logic [6:0]            shown;
      bit                    shown_set;
      r = '0;
      shown = '0;
      shown_set = 1'b0;
      case (ev.mode)
        dbm_seq_pkg::MODE_TICK: advance_sector(r);
        dbm_seq_pkg::MODE_CTL: begin
          st.sector_count = ev.start_sector;
          if (ev.ctl_mecha_rst) begin
            st.flag_bits[dbm_seq_pkg::FLG_MCI] = 1'b0;
            r.cancel_events[dbm_seq_pkg::CANCEL_MECHA] = 1'b1;
          end
          if (ev.ctl_blk_trans) st.flag_bits[dbm_seq_pkg::FLG_BLK] = 1'b1;
          if (ev.ctl_reset) begin
            st.reset_held = 1'b1;
          end else if (st.reset_held) begin
            st.reset_held = 1'b0;
            st.flag_bits[dbm_seq_pkg::FLG_DRQ] = 1'b0;
            st.flag_bits[dbm_seq_pkg::FLG_C2] = 1'b0;
            st.flag_bits[dbm_seq_pkg::FLG_BMI] = 1'b0;
            st.flag_bits[dbm_seq_pkg::FLG_RUN] = 1'b0;
            st.flag_bits[dbm_seq_pkg::FLG_BLK] = 1'b0;
            st.flag_bits[dbm_seq_pkg::FLG_MIC] = 1'b0;
            st.sector_count = '0;
            r.cancel_events[dbm_seq_pkg::CANCEL_TICK] = 1'b1;
          end
          if (!st.flag_bits[dbm_seq_pkg::FLG_BMI] && !st.flag_bits[dbm_seq_pkg::FLG_MCI])
            st.irq_reg = 1'b0;
          if (ev.ctl_start) begin
            st.flag_bits[dbm_seq_pkg::FLG_RUN] = 1'b1;
            r.event_kind = dbm_seq_pkg::EVT_TICK;
            r.event_delay = dbm_seq_pkg::START_DELAY;
          end
        end
        dbm_seq_pkg::MODE_SEEK: move_head(r, ev.seek_track, ev.seek_head, ev.seek_write);
        dbm_seq_pkg::MODE_STATUS: begin
          shown = st.flag_bits;
          shown_set = 1'b1;
          if (st.flag_bits[dbm_seq_pkg::FLG_BMI]) begin
            st.flag_bits[dbm_seq_pkg::FLG_BMI] = 1'b0;
            st.irq_reg = 1'b0;
            r.event_kind = dbm_seq_pkg::EVT_TICK;
            r.event_delay = dbm_seq_pkg::ACK_BASE + 25'(st.track_reg / ACK_TRACK_DIV);
          end
        end
        dbm_seq_pkg::MODE_MECHA: begin
          st.flag_bits[dbm_seq_pkg::FLG_MCI] = 1'b1;
          st.irq_reg = 1'b1;
        end
        dbm_seq_pkg::MODE_REZERO: move_head(r, 12'd0, 1'b0, 1'b1);
        default: ;
      endcase
      r.status_flags = shown_set ? shown : st.flag_bits;
      r.irq_line = st.irq_reg;
      r.cur_sector = st.sector_count;
      return r;
    endfunction

    function void note_event(dbm_seq_pkg::dbm_in_t ev);
      expected_q.push_back(predict(ev));
    endfunction

    function void check_result(dbm_seq_pkg::dbm_out_t got);
      dbm_seq_pkg::dbm_out_t e;
      string                 diffs;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      e = expected_q.pop_front();
      diffs = "";
      if (got.status_flags !== e.status_flags)
        diffs = {diffs, $sformatf(" status_flags %h/%h", e.status_flags, got.status_flags)};
      if (got.irq_line !== e.irq_line)
        diffs = {diffs, $sformatf(" irq_line %h/%h", e.irq_line, got.irq_line)};
      if (got.cur_sector !== e.cur_sector)
        diffs = {diffs, $sformatf(" cur_sector %h/%h", e.cur_sector, got.cur_sector)};
      if (got.disk_op !== e.disk_op)
        diffs = {diffs, $sformatf(" disk_op %h/%h", e.disk_op, got.disk_op)};
      if (got.op_head !== e.op_head)
        diffs = {diffs, $sformatf(" op_head %h/%h", e.op_head, got.op_head)};
      if (got.op_track !== e.op_track)
        diffs = {diffs, $sformatf(" op_track %h/%h", e.op_track, got.op_track)};
      if (got.op_block !== e.op_block)
        diffs = {diffs, $sformatf(" op_block %h/%h", e.op_block, got.op_block)};
      if (got.op_sector !== e.op_sector)
        diffs = {diffs, $sformatf(" op_sector %h/%h", e.op_sector, got.op_sector)};
      if (got.event_kind !== e.event_kind)
        diffs = {diffs, $sformatf(" event_kind %h/%h", e.event_kind, got.event_kind)};
      if (got.event_delay !== e.event_delay)
        diffs = {diffs, $sformatf(" event_delay %h/%h", e.event_delay, got.event_delay)};
      if (got.cancel_events !== e.cancel_events)
        diffs = {diffs, $sformatf(" cancel_events %h/%h", e.cancel_events, got.cancel_events)};
      if (diffs != "") begin
        errors++;
        if (errors <= 10) $display("result mismatch (expected/actual):%s", diffs);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  dbm_seq_pkg::dbm_in_t  in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  dbm_seq_pkg::dbm_out_t out_data;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_wr_data = 1'b0;

  dbm_scoreboard sb = new();
  int  events_sent = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  long_hold_req = 1'b0;
  int  cycle_count = 0;

  disk_buffer_manager_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic dbm_seq_pkg::dbm_in_t random_payload();
    logic [31:0] raw;
    raw = $urandom;
    return raw[$bits(dbm_seq_pkg::dbm_in_t)-1:0];
  endfunction

  function automatic dbm_seq_pkg::dbm_in_t make_plain(logic [2:0] m);
    dbm_seq_pkg::dbm_in_t p;
    p = random_payload();
    p.mode = m;
    return p;
  endfunction

  function automatic dbm_seq_pkg::dbm_in_t make_ctl(logic [7:0] sec, logic start, logic blk,
                                                    logic rst, logic mrst);
    dbm_seq_pkg::dbm_in_t p;
    p = make_plain(dbm_seq_pkg::MODE_CTL);
    p.start_sector = sec;
    p.ctl_start = start;
    p.ctl_blk_trans = blk;
    p.ctl_reset = rst;
    p.ctl_mecha_rst = mrst;
    return p;
  endfunction

  function automatic dbm_seq_pkg::dbm_in_t make_seek(logic [11:0] trk, logic hd, logic wr);
    dbm_seq_pkg::dbm_in_t p;
    p = make_plain(dbm_seq_pkg::MODE_SEEK);
    p.seek_track = trk;
    p.seek_head = hd;
    p.seek_write = wr;
    return p;
  endfunction

  task automatic send_event(input dbm_seq_pkg::dbm_in_t ev);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (in_stall);
    sb.note_event(ev);
    events_sent++;
  endtask

  task automatic write_dev_unit(input logic v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.dev_unit = v;
  endtask

  task automatic run_transfer();
    logic [7:0] first;
    int         tick_cap;
    int         ticks;
    if ($urandom_range(0, 3) == 0) begin
      send_event(make_plain(dbm_seq_pkg::MODE_REZERO));
    end else begin
      send_event(make_seek(($urandom_range(0, 2) == 0) ? dbm_seq_pkg::FAIL_TRACK
                                                       : 12'($urandom_range(0, 4095)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    end
    if ($urandom_range(0, 5) == 0)
      send_event(make_ctl(8'($urandom), 1'b0, 1'($urandom), 1'b1, 1'($urandom)));
    if ($urandom_range(0, 3) == 0) first = 8'($urandom);
    else first = 8'($urandom_range(0, 2) * dbm_seq_pkg::SEC_PER_BLK +
                    $urandom_range(60, 89));
    send_event(make_ctl(first, 1'b1, 1'($urandom), 1'b0, 1'($urandom)));
    tick_cap = $urandom_range(10, 100);
    ticks = 0;
    while (sb.running() && ticks < tick_cap) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: send_event(make_plain(dbm_seq_pkg::MODE_STATUS));
        4: send_event(make_plain(dbm_seq_pkg::MODE_MECHA));
        default: begin
          send_event(make_plain(dbm_seq_pkg::MODE_TICK));
          ticks++;
        end
      endcase
    end
    if ($urandom_range(0, 1) == 0) send_event(make_plain(dbm_seq_pkg::MODE_STATUS));
  endtask

  task automatic run_directed();
    send_event(make_plain(MODE_UNUSED));
    send_event(make_plain(dbm_seq_pkg::MODE_TICK));
    send_event(make_plain(dbm_seq_pkg::MODE_MECHA));
    send_event(make_plain(dbm_seq_pkg::MODE_STATUS));
    send_event(make_ctl(8'hff, 1'b0, 1'b0, 1'b0, 1'b1));
    send_event(make_seek(12'hfff, 1'b1, 1'b1));
    send_event(make_plain(dbm_seq_pkg::MODE_REZERO));
    send_event(make_seek(dbm_seq_pkg::FAIL_TRACK, 1'b0, 1'b0));
    send_event(make_ctl(8'd0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_event(make_plain(dbm_seq_pkg::MODE_TICK));
    send_event(make_plain(dbm_seq_pkg::MODE_STATUS));
    send_event(make_ctl(8'd5, 1'b0, 1'b0, 1'b1, 1'b0));
    send_event(make_seek(12'hfff, 1'b1, 1'b0));
    send_event(make_ctl(8'd87, 1'b1, 1'b1, 1'b0, 1'b0));
    send_event(make_ctl(8'd87, 1'b1, 1'b1, 1'b0, 1'b0));
    send_event(make_plain(dbm_seq_pkg::MODE_TICK));
    send_event(make_plain(dbm_seq_pkg::MODE_TICK));
    send_event(make_plain(dbm_seq_pkg::MODE_STATUS));
    send_event(make_ctl(8'd255, 1'b1, 1'b0, 1'b0, 1'b0));
    send_event(make_plain(dbm_seq_pkg::MODE_TICK));
    send_event(make_ctl(8'd89, 1'b1, 1'b0, 1'b0, 1'b0));
    send_event(make_plain(dbm_seq_pkg::MODE_TICK));
    send_event(make_seek(12'd100, 1'b0, 1'b1));
    send_event(make_ctl(8'd84, 1'b1, 1'b1, 1'b0, 1'b0));
    send_event(make_plain(dbm_seq_pkg::MODE_TICK));
    send_event(make_plain(dbm_seq_pkg::MODE_TICK));
    send_event(make_plain(dbm_seq_pkg::MODE_TICK));
  endtask

  initial begin
    int  next_cfg_at;
    int  target;
    bit  hold_done;
    logic dev;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_dev_unit(1'b0);
    run_directed();
    target = events_sent + RANDOM_EVENTS;
    next_cfg_at = events_sent + 300;
    dev = 1'b0;
    hold_done = 1'b0;
    while (events_sent < target) begin
      if (events_sent >= next_cfg_at) begin
        dev = ~dev;
        write_dev_unit(dev);
        next_cfg_at += 300;
      end
      if (events_sent > target - 150) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 25);
        rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 25);
      end
      if (!hold_done && events_sent >= target - RANDOM_EVENTS / 2) begin
        long_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) begin
        run_transfer();
      end else begin
        repeat ($urandom_range(1, 8)) send_event(random_payload());
      end
    end
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/dbm_seq_pkg.sv
src/dbm_seq_calc.sv
src/disk_buffer_manager_sequencer_core.sv
src/dbm_seq_chk.sv
verif/testbench.sv
